### rtl/stfr_pkg.sv
// Package of shared constants, types and the marquee font for the scrolling text renderer.
package stfr_pkg;

    // Display and message geometry.
    localparam int DISPLAY_SIZE = 24;
    localparam int MAX_CHARS    = 32;
    localparam int GLYPH_ROWS   = 5;
    localparam int GLYPH_MAX_W  = 5;
    localparam int TOP_ROW_RST  = 9;

    // Field and counter widths.
    localparam int ROW_W    = 5;
    localparam int PIX_W    = DISPLAY_SIZE;
    localparam int SCROLL_W = 9;
    localparam int CURSOR_W = 10;
    localparam int LEN_W    = 6;
    localparam int CHR_W    = 5;
    localparam int GY_W     = 3;
    localparam int ADV_W    = 3;
    localparam int WORD_W   = 64;
    localparam int TEXT_W   = MAX_CHARS * 8;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_LO     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_MID_LO = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_MID_HI = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_HI     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_LEN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_ROW     = 3'd5;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_DRAW,
        S_FLUSH,
        S_READ,
        S_SHOW
    } t_state;

    // Font entry: rows are left aligned in five bits, row 0 in the low bits.
    typedef struct packed {
        logic                              found;
        logic                              wide;
        logic [GLYPH_ROWS*GLYPH_MAX_W-1:0] rows;
    } t_glyph;

    // Rasterizer result for one glyph row.
    typedef struct packed {
        logic [PIX_W-1:0] bits;
        logic [ADV_W-1:0] adv;
    } t_raster;

    // Build a three-pixel-wide glyph, left aligned.
    function automatic t_glyph glyph3(logic [2:0] a, logic [2:0] b, logic [2:0] c,
                                      logic [2:0] d, logic [2:0] e);
        t_glyph g;
        g.found = 1'b1;
        g.wide  = 1'b0;
        g.rows  = {e, 2'b00, d, 2'b00, c, 2'b00, b, 2'b00, a, 2'b00};
        return g;
    endfunction

    // Build a five-pixel-wide glyph.
    function automatic t_glyph glyph5(logic [4:0] a, logic [4:0] b, logic [4:0] c,
                                      logic [4:0] d, logic [4:0] e);
        t_glyph g;
        g.found = 1'b1;
        g.wide  = 1'b1;
        g.rows  = {e, d, c, b, a};
        return g;
    endfunction

    // Font lookup; characters outside the font come back not found.
    function automatic t_glyph glyph_lookup(logic [7:0] ch);
        t_glyph g;
        g = '0;
        case (ch)
            "H": g = glyph3(3'd5, 3'd5, 3'd7, 3'd5, 3'd5);
            "A": g = glyph3(3'd7, 3'd5, 3'd7, 3'd5, 3'd5);
            "C": g = glyph3(3'd7, 3'd4, 3'd4, 3'd4, 3'd7);
            "K": g = glyph3(3'd5, 3'd5, 3'd6, 3'd5, 3'd5);
            "O": g = glyph3(3'd7, 3'd5, 3'd5, 3'd5, 3'd7);
            "T": g = glyph3(3'd7, 3'd2, 3'd2, 3'd2, 3'd2);
            "P": g = glyph3(3'd7, 3'd5, 3'd7, 3'd4, 3'd4);
            "R": g = glyph3(3'd7, 3'd5, 3'd6, 3'd5, 3'd5);
            "L": g = glyph3(3'd4, 3'd4, 3'd4, 3'd4, 3'd7);
            "G": g = glyph3(3'd7, 3'd4, 3'd5, 3'd5, 3'd7);
            "M": g = glyph5(5'd17, 5'd27, 5'd21, 5'd17, 5'd17);
            "N": g = glyph5(5'd17, 5'd25, 5'd21, 5'd19, 5'd17);
            "0": g = glyph3(3'd7, 3'd5, 3'd5, 3'd5, 3'd7);
            "1": g = glyph3(3'd2, 3'd6, 3'd2, 3'd2, 3'd7);
            "2": g = glyph3(3'd7, 3'd1, 3'd7, 3'd4, 3'd7);
            "3": g = glyph3(3'd7, 3'd1, 3'd3, 3'd1, 3'd7);
            "4": g = glyph3(3'd5, 3'd5, 3'd7, 3'd1, 3'd1);
            "5": g = glyph3(3'd7, 3'd4, 3'd7, 3'd1, 3'd7);
            "6": g = glyph3(3'd7, 3'd4, 3'd7, 3'd5, 3'd7);
            "7": g = glyph3(3'd7, 3'd1, 3'd2, 3'd4, 3'd4);
            "8": g = glyph3(3'd7, 3'd5, 3'd7, 3'd5, 3'd7);
            "9": g = glyph3(3'd7, 3'd5, 3'd7, 3'd1, 3'd7);
            " ": g = glyph3(3'd0, 3'd0, 3'd0, 3'd0, 3'd0);
            "-": g = glyph3(3'd0, 3'd0, 3'd7, 3'd0, 3'd0);
            "/": g = glyph3(3'd1, 3'd2, 3'd2, 3'd4, 3'd4);
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

### rtl/stfr_in_if.sv
// Request channel interface: one frame request carrying the advance flag.
interface stfr_in_if;
    logic valid;
    logic ready;
    logic advance;

    modport source (output valid, output advance, input ready);
    modport sink   (input valid, input advance, output ready);
endinterface

### rtl/stfr_out_if.sv
// Row channel interface: one rendered display row per transfer on this channel.
interface stfr_out_if;
    logic                              valid;
    logic                              ready;
    logic [stfr_pkg::ROW_W-1:0]        row_index;
    logic [stfr_pkg::PIX_W-1:0]        row_pixels;
    logic                              last_row;
    logic signed [stfr_pkg::SCROLL_W-1:0] scroll_at_render;

    modport source (output valid, output row_index, output row_pixels, output last_row,
                    output scroll_at_render, input ready);
    modport sink   (input valid, input row_index, input row_pixels, input last_row,
                    input scroll_at_render, output ready);
endinterface

### rtl/scrolling_text_frame_renderer.sv
// Scrolling text renderer top level: frame buffer, draw sequencer, config and row output.
// Each request renders one frame into a row memory and sends its 24 rows in order.
// A frame clears every buffer row, draws each used character glyph row by glyph row with a
// read-modify-write, then reads the rows out; a new request is taken only once idle again.
// Reset: text registers clear, text length 0, top row 9, scroll offset 24; the frame
// buffer is not reset and is cleared at the start of every frame.
module scrolling_text_frame_renderer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [stfr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [stfr_pkg::WORD_W-1:0]        i_cfg_data,
    stfr_in_if.sink                            i_req,
    stfr_out_if.source                         o_rsp
);

    localparam int DS = stfr_pkg::DISPLAY_SIZE;

    stfr_pkg::t_state                     r_state, n_state;
    logic [stfr_pkg::TEXT_W-1:0]          r_text;
    logic [stfr_pkg::LEN_W-1:0]           r_text_len;
    logic [stfr_pkg::ROW_W-1:0]           r_top_row;
    logic signed [stfr_pkg::SCROLL_W-1:0] r_scroll;
    logic signed [stfr_pkg::SCROLL_W-1:0] r_snap;
    logic                                 r_adv;
    logic signed [stfr_pkg::CURSOR_W-1:0] r_cursor;
    logic [stfr_pkg::ROW_W-1:0]           r_row;
    logic [stfr_pkg::CHR_W-1:0]           r_chr;
    logic [stfr_pkg::GY_W-1:0]            r_gy;
    logic                                 r_wr_en;
    logic [stfr_pkg::ROW_W-1:0]           r_wr_row;
    logic [stfr_pkg::PIX_W-1:0]           r_wr_bits;
    logic [stfr_pkg::PIX_W-1:0]           r_rd_data;
    logic [stfr_pkg::PIX_W-1:0]           r_fbuf [DS];

    logic [stfr_pkg::LEN_W-1:0]           used_len;
    logic [7:0]                           cur_char;
    logic [stfr_pkg::LEN_W:0]             draw_row;
    logic                                 draw_row_ok;
    logic                                 last_chr;
    logic                                 last_row;
    stfr_pkg::t_raster                    raster;
    logic                                 mem_we;
    logic [stfr_pkg::ROW_W-1:0]           mem_waddr;
    logic [stfr_pkg::PIX_W-1:0]           mem_wdata;
    logic                                 mem_re;
    logic [stfr_pkg::ROW_W-1:0]           mem_raddr;

    // Character walk bookkeeping.
    always_comb begin
        used_len = (r_text_len > stfr_pkg::LEN_W'(stfr_pkg::MAX_CHARS))
                 ? stfr_pkg::LEN_W'(stfr_pkg::MAX_CHARS) : r_text_len;
        cur_char    = r_text[{r_chr, 3'b000} +: 8];
        draw_row    = {2'b00, r_top_row} + {{(stfr_pkg::LEN_W + 1 - stfr_pkg::GY_W){1'b0}}, r_gy};
        draw_row_ok = draw_row < (stfr_pkg::LEN_W + 1)'(DS);
        last_chr    = {1'b0, r_chr} == (used_len - stfr_pkg::LEN_W'(1));
        last_row    = r_row == stfr_pkg::ROW_W'(DS - 1);
    end

    stfr_raster u_raster (
        .i_char      (cur_char),
        .i_glyph_row (r_gy),
        .i_cursor    (r_cursor),
        .o_raster    (raster)
    );

    // Next state, handshakes and memory port control.
    always_comb begin
        n_state     = r_state;
        i_req.ready = 1'b0;
        o_rsp.valid = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_wr_row;
        mem_wdata   = r_rd_data | r_wr_bits;
        mem_re      = 1'b0;
        mem_raddr   = r_row;
        if (r_wr_en) begin
            mem_we = 1'b1;
        end
        unique case (r_state)
            stfr_pkg::S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_state = stfr_pkg::S_CLEAR;
                end
            end
            stfr_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_row;
                mem_wdata = '0;
                if (last_row) begin
                    n_state = (used_len == '0) ? stfr_pkg::S_FLUSH : stfr_pkg::S_DRAW;
                end
            end
            stfr_pkg::S_DRAW: begin
                mem_re    = draw_row_ok;
                mem_raddr = draw_row[stfr_pkg::ROW_W-1:0];
                if (r_gy == stfr_pkg::GY_W'(stfr_pkg::GLYPH_ROWS - 1) && last_chr) begin
                    n_state = stfr_pkg::S_FLUSH;
                end
            end
            stfr_pkg::S_FLUSH: begin
                n_state = stfr_pkg::S_READ;
            end
            stfr_pkg::S_READ: begin
                mem_re  = 1'b1;
                n_state = stfr_pkg::S_SHOW;
            end
            stfr_pkg::S_SHOW: begin
                o_rsp.valid = 1'b1;
                if (o_rsp.ready) begin
                    n_state = last_row ? stfr_pkg::S_IDLE : stfr_pkg::S_READ;
                end
            end
            default: n_state = stfr_pkg::S_IDLE;
        endcase
    end

    // Row payload comes straight from the registered memory read.
    always_comb begin
        o_rsp.row_index        = r_row;
        o_rsp.row_pixels       = r_rd_data;
        o_rsp.last_row         = last_row;
        o_rsp.scroll_at_render = r_snap;
    end

    // Frame buffer: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_fbuf[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_fbuf[mem_raddr];
        end
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stfr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text     <= '0;
            r_text_len <= '0;
            r_top_row  <= stfr_pkg::ROW_W'(stfr_pkg::TOP_ROW_RST);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                stfr_pkg::CFG_TEXT_LO, stfr_pkg::CFG_TEXT_MID_LO,
                stfr_pkg::CFG_TEXT_MID_HI, stfr_pkg::CFG_TEXT_HI: begin
                    r_text[i_cfg_idx[1:0] * stfr_pkg::WORD_W +: stfr_pkg::WORD_W] <= i_cfg_data;
                end
                stfr_pkg::CFG_TEXT_LEN: begin
                    r_text_len <= i_cfg_data[stfr_pkg::LEN_W-1:0];
                end
                stfr_pkg::CFG_TOP_ROW: begin
                    r_top_row <= i_cfg_data[stfr_pkg::ROW_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Read-modify-write pipeline: the row read in one cycle is merged and written the next.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_en <= 1'b0;
        end else begin
            r_wr_en <= (r_state == stfr_pkg::S_DRAW) && draw_row_ok;
        end
        r_wr_row  <= draw_row[stfr_pkg::ROW_W-1:0];
        r_wr_bits <= raster.bits;
    end

    // Frame counters, cursor and scroll offset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scroll <= stfr_pkg::SCROLL_W'(DS);
            r_row    <= '0;
            r_chr    <= '0;
            r_gy     <= '0;
            r_adv    <= 1'b0;
            r_snap   <= '0;
            r_cursor <= '0;
        end else begin
            case (r_state)
                stfr_pkg::S_IDLE: begin
                    if (i_req.valid) begin
                        r_adv    <= i_req.advance;
                        r_snap   <= r_scroll;
                        r_cursor <= {r_scroll[stfr_pkg::SCROLL_W-1], r_scroll};
                        r_row    <= '0;
                        r_chr    <= '0;
                        r_gy     <= '0;
                    end
                end
                stfr_pkg::S_CLEAR: begin
                    r_row <= last_row ? '0 : r_row + stfr_pkg::ROW_W'(1);
                end
                stfr_pkg::S_DRAW: begin
                    if (r_gy == stfr_pkg::GY_W'(stfr_pkg::GLYPH_ROWS - 1)) begin
                        r_gy     <= '0;
                        r_chr    <= r_chr + stfr_pkg::CHR_W'(1);
                        r_cursor <= r_cursor
                                  + $signed({{(stfr_pkg::CURSOR_W - stfr_pkg::ADV_W){1'b0}},
                                             raster.adv});
                    end else begin
                        r_gy <= r_gy + stfr_pkg::GY_W'(1);
                    end
                end
                stfr_pkg::S_SHOW: begin
                    if (o_rsp.ready) begin
                        r_row <= r_row + stfr_pkg::ROW_W'(1);
                        // The final cursor is scroll plus text width, so the new offset
                        // falls below minus the width exactly when the cursor is not positive.
                        if (last_row && r_adv) begin
                            if (r_cursor < stfr_pkg::CURSOR_W'(1)) begin
                                r_scroll <= stfr_pkg::SCROLL_W'(DS);
                            end else begin
                                r_scroll <= r_snap - stfr_pkg::SCROLL_W'(1);
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

### rtl/stfr_raster.sv
// Glyph rasterizer: looks up one character and places one of its rows on the display.
module stfr_raster (
    input  logic [7:0]                          i_char,
    input  logic [stfr_pkg::GY_W-1:0]           i_glyph_row,
    input  logic signed [stfr_pkg::CURSOR_W-1:0] i_cursor,
    output stfr_pkg::t_raster                   o_raster
);

    localparam int SPAN_W = stfr_pkg::PIX_W + stfr_pkg::GLYPH_MAX_W;

    stfr_pkg::t_glyph                   glyph;
    logic [stfr_pkg::GLYPH_MAX_W-1:0]   row_bits;
    logic [SPAN_W-1:0]                  span;
    logic [SPAN_W-1:0]                  shifted;
    logic [stfr_pkg::CURSOR_W-1:0]      shift_amt;

    // Font lookup and selection of the glyph row.
    always_comb begin
        glyph    = stfr_pkg::glyph_lookup(i_char);
        row_bits = glyph.rows[i_glyph_row * stfr_pkg::GLYPH_MAX_W +: stfr_pkg::GLYPH_MAX_W];
    end

    // The leftmost glyph pixel lands on column cursor; a right shift by cursor plus
    // the glyph slot width lines it up with the display word. Far-left glyphs are clipped.
    always_comb begin
        span      = {row_bits, {stfr_pkg::PIX_W{1'b0}}};
        shift_amt = i_cursor + stfr_pkg::CURSOR_W'(stfr_pkg::GLYPH_MAX_W);
        shifted   = span >> shift_amt;
        if (i_cursor < -stfr_pkg::CURSOR_W'(stfr_pkg::GLYPH_MAX_W)) begin
            o_raster.bits = '0;
        end else begin
            o_raster.bits = shifted[stfr_pkg::PIX_W-1:0];
        end
        if (!glyph.found) begin
            o_raster.adv = '0;
        end else if (glyph.wide) begin
            o_raster.adv = stfr_pkg::ADV_W'(stfr_pkg::GLYPH_MAX_W + 1);
        end else begin
            o_raster.adv = stfr_pkg::ADV_W'(4);
        end
    end

endmodule

### verif/tb_scrolling_text_frame_renderer.sv
// Self-checking testbench for the scrolling text frame renderer.
`timescale 1ns / 1ps

module tb_scrolling_text_frame_renderer;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 4;
    localparam int RANDOM_PHASES  = 20;
    localparam int PHASE_REQUESTS = 25;
    localparam int ADVANCE_PCT    = 85;
    localparam int LEGAL_CHAR_PCT = 85;
    localparam int DRAIN_CYCLES   = 250;
    localparam int WATCHDOG_LIMIT = 5000;

    // Indexes past the register list; writes to them must be ignored.
    localparam logic [stfr_pkg::CFG_IDX_W-1:0] CFG_UNUSED_A = 3'd6;
    localparam logic [stfr_pkg::CFG_IDX_W-1:0] CFG_UNUSED_B = 3'd7;
    localparam logic [stfr_pkg::CFG_IDX_W-1:0] TEXT_REGS [4] = '{
        stfr_pkg::CFG_TEXT_LO, stfr_pkg::CFG_TEXT_MID_LO,
        stfr_pkg::CFG_TEXT_MID_HI, stfr_pkg::CFG_TEXT_HI
    };

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;
    typedef enum {STEP_CFG, STEP_REQ, STEP_REQ_BLANK} t_step_kind;

    // One glyph: pixel rows right aligned, leftmost pixel in bit width-1.
    typedef struct packed {
        logic                                 hit;
        logic [2:0]                           wd;
        logic [stfr_pkg::GLYPH_ROWS-1:0][4:0] rows;
    } t_glyph_shape;

    typedef struct packed {
        logic [stfr_pkg::ROW_W-1:0]           row;
        logic [stfr_pkg::PIX_W-1:0]           pix;
        logic                                 last;
        logic signed [stfr_pkg::SCROLL_W-1:0] scroll;
    } t_row_expect;

    typedef struct {
        t_step_kind                     kind;
        logic [stfr_pkg::CFG_IDX_W-1:0] idx;
        logic [stfr_pkg::WORD_W-1:0]    data;
        logic                           adv;
        int                             scroll;
    } t_stim_step;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [stfr_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [stfr_pkg::WORD_W-1:0]    i_cfg_data;

    stfr_in_if  req_if ();
    stfr_out_if row_if ();

    scrolling_text_frame_renderer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (row_if)
    );

    // Shadow of the block's registers and scroll state.
    logic [stfr_pkg::WORD_W-1:0] msg_words [4];
    int                          msg_len;
    int                          top_row;
    int                          scroll_pos;

    t_row_expect rows_expected [$];
    t_stim_step  directed [$];
    t_idle_mode  idle_mode = IDLE_NONE;
    string       font_chars = "HACKOTPRLGMN0123456789 -/";

    int errors       = 0;
    int frames_sent  = 0;
    int rows_checked = 0;
    int wrap_count   = 0;
    int cfg_writes   = 0;
    int idle_cycles  = 0;

    // Clock generation.
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Font of the predictor.
    function automatic t_glyph_shape shape(int w, logic [4:0] r0, logic [4:0] r1,
                                           logic [4:0] r2, logic [4:0] r3, logic [4:0] r4);
        t_glyph_shape s;
        s.hit     = 1'b1;
        s.wd      = 3'(w);
        s.rows[0] = r0;
        s.rows[1] = r1;
        s.rows[2] = r2;
        s.rows[3] = r3;
        s.rows[4] = r4;
        return s;
    endfunction

    function automatic t_glyph_shape font_shape(logic [7:0] ch);
        case (ch)
            "H": return shape(3, 5, 5, 7, 5, 5);
            "A": return shape(3, 7, 5, 7, 5, 5);
            "C": return shape(3, 7, 4, 4, 4, 7);
            "K": return shape(3, 5, 5, 6, 5, 5);
            "O": return shape(3, 7, 5, 5, 5, 7);
            "T": return shape(3, 7, 2, 2, 2, 2);
            "P": return shape(3, 7, 5, 7, 4, 4);
            "R": return shape(3, 7, 5, 6, 5, 5);
            "L": return shape(3, 4, 4, 4, 4, 7);
            "G": return shape(3, 7, 4, 5, 5, 7);
            "M": return shape(5, 17, 27, 21, 17, 17);
            "N": return shape(5, 17, 25, 21, 19, 17);
            "0": return shape(3, 7, 5, 5, 5, 7);
            "1": return shape(3, 2, 6, 2, 2, 7);
            "2": return shape(3, 7, 1, 7, 4, 7);
            "3": return shape(3, 7, 1, 3, 1, 7);
            "4": return shape(3, 5, 5, 7, 1, 1);
            "5": return shape(3, 7, 4, 7, 1, 7);
            "6": return shape(3, 7, 4, 7, 5, 7);
            "7": return shape(3, 7, 1, 2, 4, 4);
            "8": return shape(3, 7, 5, 7, 5, 7);
            "9": return shape(3, 7, 5, 7, 1, 7);
            " ": return shape(3, 0, 0, 0, 0, 0);
            "-": return shape(3, 0, 0, 7, 0, 0);
            "/": return shape(3, 1, 2, 2, 4, 4);
            default: return '0;
        endcase
    endfunction

    // Lengths above the character capacity are clamped.
    function automatic int chars_in_use();
        return (msg_len > stfr_pkg::MAX_CHARS) ? stfr_pkg::MAX_CHARS : msg_len;
    endfunction

    function automatic logic [7:0] msg_char(int pos);
        return msg_words[(pos >> 3) & 3][(pos & 7) * 8 +: 8];
    endfunction

    // Width of the message: glyph width plus gap, characters outside the font count zero.
    function automatic int msg_width();
        t_glyph_shape g;
        int w;
        w = 0;
        for (int i = 0; i < chars_in_use(); i++) begin
            g = font_shape(msg_char(i));
            if (g.hit) begin
                w += int'(g.wd) + 1;
            end
        end
        return w;
    endfunction

    // Pixels of one display row at the current scroll position.
    function automatic logic [stfr_pkg::PIX_W-1:0] row_raster(int row);
        logic [stfr_pkg::PIX_W-1:0] bits;
        t_glyph_shape               g;
        int                         y;
        int                         cursor;
        int                         col;
        int                         wd;
        bits = '0;
        y = row - top_row;
        if (y < 0 || y >= stfr_pkg::GLYPH_ROWS) begin
            return '0;
        end
        cursor = scroll_pos;
        for (int i = 0; i < chars_in_use(); i++) begin
            g = font_shape(msg_char(i));
            if (!g.hit) begin
                continue;
            end
            wd = int'(g.wd);
            for (int x = 0; x < wd; x++) begin
                col = cursor + x;
                if (g.rows[y][wd - 1 - x] && col >= 0 && col < stfr_pkg::DISPLAY_SIZE) begin
                    bits[stfr_pkg::DISPLAY_SIZE - 1 - col] = 1'b1;
                end
            end
            cursor += wd + 1;
        end
        return bits;
    endfunction

    // Queue the rows of one frame, rendered or forced blank.
    function automatic void queue_frame(bit blank, int scroll);
        t_row_expect e;
        for (int r = 0; r < stfr_pkg::DISPLAY_SIZE; r++) begin
            e.row    = stfr_pkg::ROW_W'(r);
            e.pix    = blank ? '0 : row_raster(r);
            e.last   = (r == stfr_pkg::DISPLAY_SIZE - 1);
            e.scroll = blank ? stfr_pkg::SCROLL_W'(scroll) : stfr_pkg::SCROLL_W'(scroll_pos);
            rows_expected.push_back(e);
        end
    endfunction

    // Scroll advance with wrap once the text has fully left the display.
    function automatic void step_scroll(logic adv);
        if (adv) begin
            scroll_pos--;
            if (scroll_pos < -msg_width()) begin
                scroll_pos = stfr_pkg::DISPLAY_SIZE;
                wrap_count++;
            end
        end
    endfunction

    function automatic void apply_config(logic [stfr_pkg::CFG_IDX_W-1:0] idx,
                                         logic [stfr_pkg::WORD_W-1:0] data);
        case (idx)
            stfr_pkg::CFG_TEXT_LO:     msg_words[0] = data;
            stfr_pkg::CFG_TEXT_MID_LO: msg_words[1] = data;
            stfr_pkg::CFG_TEXT_MID_HI: msg_words[2] = data;
            stfr_pkg::CFG_TEXT_HI:     msg_words[3] = data;
            stfr_pkg::CFG_TEXT_LEN:    msg_len = int'(data[stfr_pkg::LEN_W-1:0]);
            stfr_pkg::CFG_TOP_ROW:     top_row = int'(data[stfr_pkg::ROW_W-1:0]);
            default: ;
        endcase
    endfunction

    function automatic int sender_pct();
        case (idle_mode)
            IDLE_SENDER: return 69;
            IDLE_BOTH:   return 21;
            default:     return 0;
        endcase
    endfunction

    function automatic int receiver_pct();
        case (idle_mode)
            IDLE_RECEIVER: return 69;
            IDLE_BOTH:     return 21;
            default:       return 0;
        endcase
    endfunction

    function automatic void add_step(t_step_kind kind, logic [stfr_pkg::CFG_IDX_W-1:0] idx,
                                     logic [stfr_pkg::WORD_W-1:0] data, logic adv,
                                     int scroll);
        directed.push_back('{kind, idx, data, adv, scroll});
    endfunction

    // Mostly font characters, sometimes any byte.
    function automatic logic [7:0] rand_char();
        if ($urandom_range(0, 99) < LEGAL_CHAR_PCT) begin
            return font_chars[$urandom_range(0, font_chars.len() - 1)];
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Register write; the enable stays high until the next request goes out.
    task automatic cfg_write(logic [stfr_pkg::CFG_IDX_W-1:0] idx,
                             logic [stfr_pkg::WORD_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        apply_config(idx, data);
        cfg_writes++;
    endtask

    // Issue one frame request and predict its rows once it is accepted.
    task automatic send_request(logic adv, bit blank, int scroll);
        int pct;
        pct = sender_pct();
        i_cfg_we <= 1'b0;
        if ($urandom_range(0, 99) < pct) begin
            req_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < pct);
        end
        req_if.valid   <= 1'b1;
        req_if.advance <= adv;
        do @(posedge i_clk); while (!req_if.ready);
        queue_frame(blank, scroll);
        step_scroll(adv);
        frames_sent++;
    endtask

    // Drop the request and let every outstanding row arrive.
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (rows_expected.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // New message, length and top row, with the odd write to an unused index.
    task automatic randomize_config();
        logic [stfr_pkg::WORD_W-1:0] w;
        int                          len;
        int                          top;
        for (int k = 0; k < 4; k++) begin
            for (int b = 0; b < 8; b++) begin
                w[b * 8 +: 8] = rand_char();
            end
            cfg_write(TEXT_REGS[k], w);
        end
        case ($urandom_range(0, 9))
            0:       len = 0;
            1:       len = stfr_pkg::MAX_CHARS;
            2:       len = $urandom_range(stfr_pkg::MAX_CHARS + 1, 63);
            3, 4, 5: len = $urandom_range(1, 6);
            default: len = $urandom_range(0, stfr_pkg::MAX_CHARS);
        endcase
        w = {$urandom, $urandom};
        w[stfr_pkg::LEN_W-1:0] = stfr_pkg::LEN_W'(len);
        cfg_write(stfr_pkg::CFG_TEXT_LEN, w);
        case ($urandom_range(0, 5))
            0:       top = 0;
            1:       top = $urandom_range(stfr_pkg::DISPLAY_SIZE - stfr_pkg::GLYPH_ROWS + 1, 31);
            default: top = $urandom_range(0, stfr_pkg::DISPLAY_SIZE - stfr_pkg::GLYPH_ROWS);
        endcase
        w = {$urandom, $urandom};
        w[stfr_pkg::ROW_W-1:0] = stfr_pkg::ROW_W'(top);
        cfg_write(stfr_pkg::CFG_TOP_ROW, w);
        if ($urandom_range(0, 3) == 0) begin
            cfg_write($urandom_range(0, 1) ? CFG_UNUSED_A : CFG_UNUSED_B, {$urandom, $urandom});
        end
    endtask

    task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Row sink backpressure.
    always @(posedge i_clk) begin
        row_if.ready <= ($urandom_range(0, 99) >= receiver_pct());
    end

    // Compare each accepted row with the oldest prediction.
    always @(posedge i_clk) begin : row_monitor
        t_row_expect want;
        if (i_rst_n && row_if.valid && row_if.ready) begin
            rows_checked++;
            if (rows_expected.size() == 0) begin
                errors++;
                $display("%0t ns: row %0d arrived with no request pending", $time,
                         row_if.row_index);
            end else begin
                want = rows_expected.pop_front();
                check_field("row_index", want.row, row_if.row_index);
                check_field("row_pixels", want.pix, row_if.row_pixels);
                check_field("last_row", want.last, row_if.last_row);
                check_field("scroll_at_render", $signed(want.scroll),
                            $signed(row_if.scroll_at_render));
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (req_if.valid && req_if.ready) ||
            (row_if.valid && row_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles", $time, idle_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Main sequence: reset, directed table, random phases, drain.
    initial begin
        $timeformat(-9, 0, "", 0);
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= stfr_pkg::CFG_TEXT_LO;
        i_cfg_data     <= '0;
        req_if.valid   <= 1'b0;
        req_if.advance <= 1'b0;

        for (int k = 0; k < 4; k++) begin
            msg_words[k] = '0;
        end
        msg_len    = 0;
        top_row    = stfr_pkg::TOP_ROW_RST;
        scroll_pos = stfr_pkg::DISPLAY_SIZE;

        // Empty text after reset: blank frames, scroll starts at the display size.
        add_step(STEP_REQ_BLANK, stfr_pkg::CFG_TEXT_LO, '0, 1'b0, 24);
        add_step(STEP_REQ_BLANK, stfr_pkg::CFG_TEXT_LO, '0, 1'b1, 24);
        add_step(STEP_REQ_BLANK, stfr_pkg::CFG_TEXT_LO, '0, 1'b1, 23);
        // Characters outside the font draw nothing and take no width.
        add_step(STEP_CFG, stfr_pkg::CFG_TEXT_LO, '1, 1'b0, 0);
        add_step(STEP_CFG, stfr_pkg::CFG_TEXT_LEN, 64'd8, 1'b0, 0);
        add_step(STEP_REQ_BLANK, stfr_pkg::CFG_TEXT_LO, '0, 1'b0, 22);
        // Writes past the register list change nothing.
        add_step(STEP_CFG, CFG_UNUSED_A, '1, 1'b0, 0);
        add_step(STEP_CFG, CFG_UNUSED_B, '1, 1'b0, 0);
        add_step(STEP_REQ_BLANK, stfr_pkg::CFG_TEXT_LO, '0, 1'b1, 22);
        // Full message with every glyph and embedded NUL characters; character 0 is rightmost in each literal.
        add_step(STEP_CFG, stfr_pkg::CFG_TEXT_LO, "RPTOKCAH", 1'b0, 0);
        add_step(STEP_CFG, stfr_pkg::CFG_TEXT_MID_LO, "3210NMGL", 1'b0, 0);
        add_step(STEP_CFG, stfr_pkg::CFG_TEXT_MID_HI, "- 987654", 1'b0, 0);
        add_step(STEP_CFG, stfr_pkg::CFG_TEXT_HI, 64'h4E00_4D48_002F_2D4D, 1'b0, 0);
        add_step(STEP_CFG, stfr_pkg::CFG_TEXT_LEN, 64'd32, 1'b0, 0);
        add_step(STEP_CFG, stfr_pkg::CFG_TOP_ROW, 64'd0, 1'b0, 0);
        add_step(STEP_REQ, stfr_pkg::CFG_TEXT_LO, '0, 1'b0, 0);
        add_step(STEP_REQ, stfr_pkg::CFG_TEXT_LO, '0, 1'b1, 0);
        // Top rows near and past the bottom of the display.
        add_step(STEP_CFG, stfr_pkg::CFG_TOP_ROW, 64'd19, 1'b0, 0);
        add_step(STEP_REQ, stfr_pkg::CFG_TEXT_LO, '0, 1'b1, 0);
        add_step(STEP_CFG, stfr_pkg::CFG_TOP_ROW, 64'd23, 1'b0, 0);
        add_step(STEP_REQ, stfr_pkg::CFG_TEXT_LO, '0, 1'b1, 0);
        add_step(STEP_CFG, stfr_pkg::CFG_TOP_ROW, '1, 1'b0, 0);
        add_step(STEP_REQ, stfr_pkg::CFG_TEXT_LO, '0, 1'b1, 0);
        // Over-long length and masking of the upper data bits.
        add_step(STEP_CFG, stfr_pkg::CFG_TEXT_LEN, '1, 1'b0, 0);
        add_step(STEP_CFG, stfr_pkg::CFG_TOP_ROW, 64'hFFFF_FFFF_FFFF_FFE2, 1'b0, 0);
        add_step(STEP_REQ, stfr_pkg::CFG_TEXT_LO, '0, 1'b1, 0);
        add_step(STEP_CFG, stfr_pkg::CFG_TEXT_LEN, 64'h1234_5678_9ABC_DE05, 1'b0, 0);
        add_step(STEP_REQ, stfr_pkg::CFG_TEXT_LO, '0, 1'b1, 0);
        // NUL characters between glyphs do not end the message.
        add_step(STEP_CFG, stfr_pkg::CFG_TEXT_LO, 64'h4E00_004D_0000_4800, 1'b0, 0);
        add_step(STEP_CFG, stfr_pkg::CFG_TEXT_LEN, 64'd8, 1'b0, 0);
        add_step(STEP_REQ, stfr_pkg::CFG_TEXT_LO, '0, 1'b1, 0);
        // Empty text again.
        add_step(STEP_CFG, stfr_pkg::CFG_TEXT_LEN, 64'd0, 1'b0, 0);
        add_step(STEP_REQ, stfr_pkg::CFG_TEXT_LO, '0, 1'b1, 0);
        add_step(STEP_REQ, stfr_pkg::CFG_TEXT_LO, '0, 1'b0, 0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table.
        foreach (directed[i]) begin
            case (directed[i].kind)
                STEP_CFG: begin
                    wait_drained();
                    cfg_write(directed[i].idx, directed[i].data);
                end
                STEP_REQ:       send_request(directed[i].adv, 1'b0, 0);
                STEP_REQ_BLANK: send_request(directed[i].adv, 1'b1, directed[i].scroll);
                default: ;
            endcase
        end

        // Random phases, cycling through the idling modes.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_drained();
            idle_mode = t_idle_mode'(phase % 4);
            randomize_config();
            repeat (PHASE_REQUESTS) begin
                send_request($urandom_range(0, 99) < ADVANCE_PCT, 1'b0, 0);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (rows_expected.size() != 0) begin
            errors++;
            $display("%0t ns: %0d predicted rows never arrived", $time, rows_expected.size());
        end
        $display("Rendered %0d frames, %0d rows compared, %0d scroll wraps, %0d register writes.",
                 frames_sent, rows_checked, wrap_count, cfg_writes);
        $display("Idling modes on both channels, empty, clipped and over-long messages covered.");
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
